>>> design/pinio_pkg.sv
`default_nettype none
package pinio_pkg;

	// Item kinds on the command channel
	localparam logic [1:0] OP_WRITE      = 2'd0;
	localparam logic [1:0] OP_READ       = 2'd1;
	localparam logic [1:0] OP_TIMER      = 2'd2;
	localparam logic [1:0] OP_ZERO_CROSS = 2'd3;

	// Register offsets in the I/O window
	localparam logic [3:0] OFF_DIAG_DIGIT = 4'h2;
	localparam logic [3:0] OFF_CONT_SOL   = 4'h3;
	localparam logic [3:0] OFF_MATRIX     = 4'h4;
	localparam logic [3:0] OFF_SOUND      = 4'h5;
	localparam logic [3:0] OFF_HK_RELEASE = 4'h6;
	localparam logic [3:0] OFF_ZC_CLEAR   = 4'h7;
	localparam logic [3:0] OFF_LED_OFF    = 4'h8;
	localparam logic [3:0] OFF_LED_ON     = 4'h9;
	localparam logic [3:0] OFF_IRQ_ACK    = 4'ha;
	localparam logic [3:0] OFF_SEG_READ   = 4'hb;
	localparam logic [3:0] OFF_SOL_IDLE_D = 4'hd;
	localparam logic [3:0] OFF_SOL_IDLE_E = 4'he;
	localparam logic [3:0] OFF_SWITCH     = 4'hf;

	localparam int          NumDigits    = 5;
	localparam int          NumGroups    = 7;
	localparam logic [2:0]  LastBeat     = 3'(NumDigits - 1);
	localparam logic [3:0]  TestColumn   = 4'hf;
	localparam logic [7:0]  HkReleaseKey = 8'hff;
	localparam logic [7:0]  BusIdleByte  = 8'hff;
	localparam logic [1:0]  DividerTop   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  offset;
		logic [7:0]  wdata;
		logic [3:0]  scan_column;
		logic [7:0]  switch_byte;
		logic        self_test;
		logic [2:0]  digit_column;
		logic [39:0] digit_bytes;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        command_irq;
		logic        housekeeping_irq;
		logic        housekeeping_run;
		logic        sound_strobe;
		logic [31:0] solenoid_bits;
		logic [17:0] solenoid_bits_high;
		logic [6:0]  diag_segments;
		logic        seg_valid;
		logic [5:0]  seg_index;
		logic [9:0]  seg_word;
		logic        last;
	} res_item_t;

	typedef struct packed {
		logic [1:0]  tick_divider;
		logic        command_irq_level;
		logic        zero_cross_irq_level;
		logic        housekeeping_released;
		logic [6:0]  diag_digit_segments;
		logic        diag_led_enabled;
		logic        display_blanked;
		logic [31:0] solenoid_low_word;
		logic [17:0] solenoid_high_word;
	} state_t;

	function automatic logic [6:0] hex_segments(input logic [3:0] nib);
		logic [6:0] seg;
		unique case (nib)
			4'h0: seg = 7'h3f;
			4'h1: seg = 7'h06;
			4'h2: seg = 7'h5b;
			4'h3: seg = 7'h4f;
			4'h4: seg = 7'h66;
			4'h5: seg = 7'h6d;
			4'h6: seg = 7'h7d;
			4'h7: seg = 7'h07;
			4'h8: seg = 7'h7f;
			4'h9: seg = 7'h6f;
			4'ha: seg = 7'h77;
			4'hb: seg = 7'h7c;
			4'hc: seg = 7'h39;
			4'hd: seg = 7'h5e;
			4'he: seg = 7'h79;
			4'hf: seg = 7'h71;
			default: seg = 7'h00;
		endcase
		return seg;
	endfunction

endpackage
`default_nettype wire

>>> design/pinio_if.sv
`default_nettype none
interface pinio_cmd_if;
	logic                  valid;
	logic                  ready;
	pinio_pkg::cmd_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pinio_res_if;
	logic                  valid;
	logic                  ready;
	pinio_pkg::res_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/pinio_decode.sv
`default_nettype none
module pinio_decode (
	input  wire pinio_pkg::cmd_item_t item,
	input  wire pinio_pkg::state_t    state,
	input  wire logic [2:0]           beat,
	input  wire logic                 beat_last,
	output pinio_pkg::state_t         state_next,
	output pinio_pkg::res_item_t      result
);

	logic [7:0]  rd;
	logic        snd;
	logic        seg_burst;
	logic [7:0]  code;
	logic [2:0]  grp;
	logic        hit;
	logic [2:0]  bit_idx;
	logic [41:0] mat_cur;
	logic [41:0] mat_next;
	logic [pinio_pkg::NumDigits-1:0][7:0] bytes_a;
	logic [7:0]  seg_byte;

	assign bytes_a  = item.digit_bytes;
	assign seg_byte = bytes_a[beat];
	assign seg_burst = (item.op == pinio_pkg::OP_READ) && (item.offset == pinio_pkg::OFF_SEG_READ);

	// Matrix code: group from bits 7..3, a bit is set only for low bits 1..6
	// in the block of eight that belongs to the group.
	assign code = item.wdata;
	always_comb begin
		priority if (code[7:6] != 2'b00 || code[5:3] == 3'd7) begin
			grp = 3'd6;
		end else if (code[5:4] == 2'b00) begin
			grp = 3'd0;
		end else begin
			grp = code[5:3] - 3'd1;
		end
	end
	assign hit     = (code[7:3] == {2'b00, grp + 3'd1}) && (code[2:0] != 3'd0)
		&& (code[2:0] != 3'd7);
	assign bit_idx = code[2:0] - 3'd1;
	assign mat_cur = {state.solenoid_high_word, state.solenoid_low_word[31:8]};

	always_comb begin
		mat_next = mat_cur;
		if (code == 8'h00) begin
			mat_next = '0;
		end else begin
			for (int g = 0; g < pinio_pkg::NumGroups; g++) begin
				if (grp == 3'(g)) begin
					mat_next[6*g +: 6] = hit ? (6'b000001 << bit_idx) : 6'b000000;
				end
			end
		end
	end

	always_comb begin
		state_next = state;
		rd  = 8'h00;
		snd = 1'b0;
		unique case (item.op)
			pinio_pkg::OP_WRITE: begin
				unique case (item.offset)
					pinio_pkg::OFF_DIAG_DIGIT: begin
						state_next.diag_digit_segments = pinio_pkg::hex_segments(item.wdata[7:4]);
						state_next.display_blanked     = ~item.wdata[0];
					end
					pinio_pkg::OFF_CONT_SOL: begin
						state_next.solenoid_low_word[7:0] = item.wdata;
					end
					pinio_pkg::OFF_MATRIX: begin
						state_next.solenoid_low_word[31:8] = mat_next[23:0];
						state_next.solenoid_high_word      = mat_next[41:24];
					end
					pinio_pkg::OFF_SOUND: begin
						snd = 1'b1;
					end
					pinio_pkg::OFF_HK_RELEASE: begin
						if (item.wdata == pinio_pkg::HkReleaseKey) begin
							state_next.housekeeping_released = 1'b1;
						end
					end
					pinio_pkg::OFF_ZC_CLEAR: state_next.zero_cross_irq_level = 1'b0;
					pinio_pkg::OFF_LED_OFF:  state_next.diag_led_enabled = 1'b0;
					pinio_pkg::OFF_LED_ON:   state_next.diag_led_enabled = 1'b1;
					default: ;
				endcase
			end
			pinio_pkg::OP_READ: begin
				unique case (item.offset)
					pinio_pkg::OFF_IRQ_ACK: begin
						state_next.command_irq_level = 1'b0;
						rd = pinio_pkg::BusIdleByte;
					end
					pinio_pkg::OFF_SEG_READ,
					pinio_pkg::OFF_SOL_IDLE_D,
					pinio_pkg::OFF_SOL_IDLE_E: rd = pinio_pkg::BusIdleByte;
					pinio_pkg::OFF_SWITCH: begin
						rd = {item.switch_byte[7]
							| ((item.scan_column == pinio_pkg::TestColumn) & item.self_test),
							item.switch_byte[6:0]};
					end
					default: ;
				endcase
			end
			pinio_pkg::OP_TIMER: begin
				if (state.tick_divider == pinio_pkg::DividerTop) begin
					state_next.tick_divider      = 2'd0;
					state_next.command_irq_level = 1'b1;
				end else begin
					state_next.tick_divider = state.tick_divider + 2'd1;
				end
			end
			pinio_pkg::OP_ZERO_CROSS: state_next.zero_cross_irq_level = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		result.read_data          = rd;
		result.command_irq        = state_next.command_irq_level;
		result.housekeeping_irq   = state_next.zero_cross_irq_level;
		result.housekeeping_run   = state_next.housekeeping_released;
		result.sound_strobe       = snd;
		result.solenoid_bits      = state_next.solenoid_low_word;
		result.solenoid_bits_high = state_next.solenoid_high_word;
		result.diag_segments      = state_next.diag_led_enabled
			? state_next.diag_digit_segments : 7'h00;
		result.seg_valid          = seg_burst;
		result.seg_index          = seg_burst ? {beat, item.digit_column} : 6'd0;
		result.seg_word           = (seg_burst && !state.display_blanked)
			? {seg_byte[7], seg_byte[7], 1'b0, seg_byte[6:0]} : 10'd0;
		result.last               = beat_last;
	end

endmodule
`default_nettype wire

>>> design/pinball_io_register_block.sv
`default_nettype none
// Channel | Dir | Payload              | Handshake
// cmd     | in  | pinio_pkg::cmd_item_t | valid/ready, transfer when both high
// res     | out | pinio_pkg::res_item_t | valid/ready, transfer when both high
//
// An accepted item sits in an input register; decode logic feeds a result register.
// Each item gives one result; a read of the segment register emits five results.
// The result register lets the next item be taken while a result waits for its transfer.
// arst_n clears the I/O state with the tick divider, the beat counter and both valid flags.
// A stalled result holds the input register, which then stalls cmd.
module pinball_io_register_block (
	input  wire logic      clk,
	input  wire logic      arst_n,
	pinio_cmd_if.sink      cmd,
	pinio_res_if.source    res
);

	pinio_pkg::cmd_item_t cmd_s1;
	logic                 cmd_valid_s1;
	logic [2:0]           beat_q;
	pinio_pkg::state_t    state_q;
	pinio_pkg::state_t    state_next;
	pinio_pkg::res_item_t result;
	pinio_pkg::res_item_t res_q;
	logic                 res_valid_q;
	logic                 load;
	logic                 seg_burst;
	logic                 beat_last;

	assign load      = cmd_valid_s1 && (!res_valid_q || res.ready);
	assign seg_burst = (cmd_s1.op == pinio_pkg::OP_READ)
		&& (cmd_s1.offset == pinio_pkg::OFF_SEG_READ);
	assign beat_last = !seg_burst || (beat_q == pinio_pkg::LastBeat);
	assign cmd.ready = !cmd_valid_s1 || (load && beat_last);

	pinio_decode u_decode (
		.item       (cmd_s1),
		.state      (state_q),
		.beat       (beat_q),
		.beat_last  (beat_last),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			beat_q       <= 3'd0;
			state_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				cmd_valid_s1 <= 1'b1;
			end else if (load && beat_last) begin
				cmd_valid_s1 <= 1'b0;
			end
			if (load) begin
				beat_q <= beat_last ? 3'd0 : beat_q + 3'd1;
			end
			if (load && beat_last) begin
				state_q <= state_next;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.payload;
		end
		if (load) begin
			res_q <= result;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule
`default_nettype wire

>>> bench/tb_pinball_io_register_block.sv
`default_nettype none
module tb_pinball_io_register_block;

	localparam int         IdleLimit   = 1000;
	localparam int         DrainCycles = 16;
	localparam int         RandItems   = 250;
	localparam int         SegBeats    = 5;
	localparam logic [7:0] IdleRead    = 8'hff;
	localparam logic [7:0] ReleaseKey  = 8'hff;
	localparam logic [3:0] SelfTestCol = 4'hf;
	localparam logic [1:0] DivWrap     = 2'd3;
	// offsets with no register behind them
	localparam logic [3:0] OFF_NONE_0  = 4'h0;
	localparam logic [3:0] OFF_NONE_C  = 4'hc;

	typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY3, STALL_LONG} stall_mode_t;

	typedef struct {
		logic [1:0]  op;
		logic [3:0]  off;
		logic [7:0]  wd;
		logic [3:0]  col;
		logic [7:0]  sw;
		logic        st;
		logic [2:0]  dcol;
		logic [39:0] bytes;
		bit          fix;
		logic [7:0]  rdv;
	} dir_row_t;

	typedef struct packed {
		bit         fix;
		logic [7:0] value;
	} rd_pin_t;

	localparam int NumRows = 26;

	// fix/rdv: read data known by inspection, else taken from the predictor
	dir_row_t dir_tab [NumRows] = '{
		'{pinio_pkg::OP_READ, pinio_pkg::OFF_SWITCH,
			8'h00, 4'hf, 8'h00, 1'b1, 3'd0, 40'h0, 1'b1, 8'h80},
		'{pinio_pkg::OP_READ, pinio_pkg::OFF_SWITCH,
			8'hff, 4'hc, 8'ha5, 1'b1, 3'd7, 40'h0, 1'b1, 8'ha5},
		'{pinio_pkg::OP_READ, OFF_NONE_0,
			8'hff, 4'hf, 8'hff, 1'b1, 3'd7, 40'h0, 1'b1, 8'h00},
		'{pinio_pkg::OP_READ, OFF_NONE_C,
			8'h00, 4'h0, 8'hff, 1'b0, 3'd0, 40'h0, 1'b1, 8'h00},
		'{pinio_pkg::OP_READ, pinio_pkg::OFF_SOL_IDLE_D,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b1, 8'hff},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_DIAG_DIGIT,
			8'hf1, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_LED_ON,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_READ, pinio_pkg::OFF_SEG_READ,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd7, 40'hff807f0001, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_DIAG_DIGIT,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_READ, pinio_pkg::OFF_SEG_READ,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'hffffffffff, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_CONT_SOL,
			8'hff, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_MATRIX,
			8'h09, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_MATRIX,
			8'h0e, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_MATRIX,
			8'h39, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_MATRIX,
			8'h29, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_MATRIX,
			8'h0f, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_MATRIX,
			8'hff, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_MATRIX,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_SOUND,
			8'ha5, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_WRITE, pinio_pkg::OFF_HK_RELEASE,
			8'hff, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_TIMER, OFF_NONE_0,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_TIMER, OFF_NONE_0,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_TIMER, OFF_NONE_0,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_TIMER, OFF_NONE_0,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00},
		'{pinio_pkg::OP_READ, pinio_pkg::OFF_IRQ_ACK,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b1, 8'hff},
		'{pinio_pkg::OP_ZERO_CROSS, OFF_NONE_0,
			8'h00, 4'h0, 8'h00, 1'b0, 3'd0, 40'h0, 1'b0, 8'h00}
	};

	logic clk;
	logic arst_n;

	pinio_cmd_if cmd_bus ();
	pinio_res_if res_bus ();

	pinball_io_register_block dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	const logic [6:0] seg_lut [16] = '{
		7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07,
		7'h7f, 7'h6f, 7'h77, 7'h7c, 7'h39, 7'h5e, 7'h79, 7'h71
	};

	pinio_pkg::state_t    io_state;
	pinio_pkg::cmd_item_t bus_items [$];
	rd_pin_t              read_pins [$];
	pinio_pkg::res_item_t results_due [$];
	int                   items_taken;
	int                   idle_cycles;
	int                   mismatches;
	bit                   stim_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic pinio_pkg::res_item_t status_word(input logic [7:0] rd,
		input logic snd);
		pinio_pkg::res_item_t r;
		r = '0;
		r.read_data          = rd;
		r.command_irq        = io_state.command_irq_level;
		r.housekeeping_irq   = io_state.zero_cross_irq_level;
		r.housekeeping_run   = io_state.housekeeping_released;
		r.sound_strobe       = snd;
		r.solenoid_bits      = io_state.solenoid_low_word;
		r.solenoid_bits_high = io_state.solenoid_high_word;
		r.diag_segments      = io_state.diag_led_enabled ? io_state.diag_digit_segments : 7'd0;
		r.last               = 1'b1;
		return r;
	endfunction

	// one-of-42 decode; a code outside its group's six slots only clears the group
	task automatic matrix_decode(input logic [7:0] code);
		int         g;
		int         first;
		logic [5:0] six;
		if (code == 8'h00) begin
			io_state.solenoid_low_word[31:8] = '0;
			io_state.solenoid_high_word = '0;
		end else begin
			if (code < 8'h10)
				g = 0;
			else if (code >= 8'h38)
				g = 6;
			else
				g = int'(code >> 3) - 1;
			first = 8 * g + 9;
			six = (code >= first && code <= first + 5) ? 6'(1 << (code - first)) : 6'd0;
			if (g < 4)
				io_state.solenoid_low_word[8 + 6 * g +: 6] = six;
			else
				io_state.solenoid_high_word[6 * (g - 4) +: 6] = six;
		end
	endtask

	task automatic apply_bus_item(input pinio_pkg::cmd_item_t c, input rd_pin_t pin);
		pinio_pkg::res_item_t r;
		logic [7:0]           rd;
		logic [7:0]           b;
		logic                 snd;
		int                   i;
		rd = '0;
		snd = 1'b0;
		case (c.op)
			pinio_pkg::OP_WRITE: begin
				case (c.offset)
					pinio_pkg::OFF_DIAG_DIGIT: begin
						io_state.diag_digit_segments = seg_lut[c.wdata[7:4]];
						io_state.display_blanked = ~c.wdata[0];
					end
					pinio_pkg::OFF_CONT_SOL:   io_state.solenoid_low_word[7:0] = c.wdata;
					pinio_pkg::OFF_MATRIX:     matrix_decode(c.wdata);
					pinio_pkg::OFF_SOUND:      snd = 1'b1;
					pinio_pkg::OFF_HK_RELEASE:
						if (c.wdata == ReleaseKey) io_state.housekeeping_released = 1'b1;
					pinio_pkg::OFF_ZC_CLEAR:   io_state.zero_cross_irq_level = 1'b0;
					pinio_pkg::OFF_LED_OFF:    io_state.diag_led_enabled = 1'b0;
					pinio_pkg::OFF_LED_ON:     io_state.diag_led_enabled = 1'b1;
					default: ;
				endcase
			end
			pinio_pkg::OP_READ: begin
				case (c.offset)
					pinio_pkg::OFF_IRQ_ACK: begin
						io_state.command_irq_level = 1'b0;
						rd = IdleRead;
					end
					pinio_pkg::OFF_SEG_READ: begin
						for (i = 0; i < SegBeats; i++) begin
							b = c.digit_bytes[8 * i +: 8];
							r = status_word(IdleRead, 1'b0);
							r.seg_valid = 1'b1;
							r.seg_index = 6'(8 * i + c.digit_column);
							r.seg_word  = io_state.display_blanked ? 10'd0
								: {b[7], b[7], 1'b0, b[6:0]};
							r.last      = (i == SegBeats - 1);
							results_due.push_back(r);
						end
						return;
					end
					pinio_pkg::OFF_SOL_IDLE_D, pinio_pkg::OFF_SOL_IDLE_E: rd = IdleRead;
					pinio_pkg::OFF_SWITCH: begin
						rd = c.switch_byte;
						if (c.scan_column == SelfTestCol) rd[7] = rd[7] | c.self_test;
					end
					default: ;
				endcase
			end
			pinio_pkg::OP_TIMER: begin
				if (io_state.tick_divider == DivWrap) begin
					io_state.tick_divider = '0;
					io_state.command_irq_level = 1'b1;
				end else begin
					io_state.tick_divider = io_state.tick_divider + 2'd1;
				end
			end
			default: io_state.zero_cross_irq_level = 1'b1;
		endcase
		if (pin.fix) rd = pin.value;
		results_due.push_back(status_word(rd, snd));
	endtask

	function automatic pinio_pkg::cmd_item_t random_bus_item();
		pinio_pkg::cmd_item_t c;
		int                   pick;
		int                   g;
		c.op           = pinio_pkg::OP_WRITE;
		c.offset       = 4'($urandom_range(0, 15));
		c.wdata        = 8'($urandom_range(0, 255));
		c.scan_column  = 4'($urandom_range(0, 15));
		c.switch_byte  = 8'($urandom_range(0, 255));
		c.self_test    = 1'($urandom_range(0, 1));
		c.digit_column = 3'($urandom_range(0, 7));
		c.digit_bytes  = 40'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			if ($urandom_range(0, 4) != 0) c.offset = 4'($urandom_range(2, 9));
			if (c.offset == pinio_pkg::OFF_MATRIX && $urandom_range(0, 9) < 7) begin
				g = $urandom_range(0, 6);
				c.wdata = 8'(8 * g + 9 + $urandom_range(0, 5));
			end
			if (c.offset == pinio_pkg::OFF_HK_RELEASE && $urandom_range(0, 1) == 1)
				c.wdata = ReleaseKey;
		end else if (pick < 80) begin
			c.op = pinio_pkg::OP_READ;
			pick = $urandom_range(0, 99);
			if (pick < 30)
				c.offset = pinio_pkg::OFF_SEG_READ;
			else if (pick < 50)
				c.offset = pinio_pkg::OFF_SWITCH;
			else if (pick < 65)
				c.offset = pinio_pkg::OFF_IRQ_ACK;
			if (c.offset == pinio_pkg::OFF_SWITCH && $urandom_range(0, 2) == 0)
				c.scan_column = SelfTestCol;
		end else if (pick < 92) begin
			c.op = pinio_pkg::OP_TIMER;
		end else begin
			c.op = pinio_pkg::OP_ZERO_CROSS;
		end
		return c;
	endfunction

	task automatic field_check(input string name, input logic [39:0] want, input logic [39:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin : build_stimulus
		int       k;
		rd_pin_t  pin;
		dir_row_t row;
		for (k = 0; k < NumRows; k++) begin
			row = dir_tab[k];
			bus_items.push_back(pinio_pkg::cmd_item_t'{row.op, row.off, row.wd, row.col,
				row.sw, row.st, row.dcol, row.bytes});
			pin.fix = row.fix;
			pin.value = row.rdv;
			read_pins.push_back(pin);
		end
		for (k = 0; k < RandItems; k++) begin
			bus_items.push_back(random_bus_item());
			read_pins.push_back('0);
		end
	end

	initial begin : cmd_driver
		int burst;
		int gap;
		int n;
		cmd_bus.valid = 1'b0;
		cmd_bus.payload = '0;
		stim_done = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		while (bus_items.size() != 0) begin
			burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
			gap = $urandom_range(0, 6);
			while (burst > 0 && bus_items.size() != 0) begin
				cmd_bus.payload = bus_items.pop_front();
				cmd_bus.valid = 1'b1;
				n = items_taken;
				do @(negedge clk); while (items_taken == n);
				burst--;
			end
			if (gap > 0) begin
				cmd_bus.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		cmd_bus.valid = 1'b0;
		stim_done = 1'b1;
	end

	initial begin : res_stall
		stall_mode_t mode;
		int          len;
		int          k;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			len = $urandom_range(8, 48);
			for (k = 0; k < len; k++) begin
				@(negedge clk);
				case (mode)
					STALL_NONE:   res_bus.ready = 1'b1;
					STALL_COIN:   res_bus.ready = 1'($urandom_range(0, 1));
					STALL_EVERY3: res_bus.ready = (k % 3) != 2;
					default:      res_bus.ready = (k % 12) >= 8;
				endcase
			end
		end
	end

	// predict on each cmd transfer, then check any res transfer in the same edge
	always @(posedge clk) begin : io_monitor
		pinio_pkg::res_item_t want;
		pinio_pkg::res_item_t got;
		logic                 moved;
		moved = 1'b0;
		if (cmd_bus.valid && cmd_bus.ready) begin
			apply_bus_item(cmd_bus.payload, read_pins.pop_front());
			items_taken++;
			moved = 1'b1;
		end
		if (res_bus.valid && res_bus.ready) begin
			moved = 1'b1;
			got = res_bus.payload;
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0h", $time, got);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				field_check("read_data", want.read_data, got.read_data);
				field_check("command_irq", want.command_irq, got.command_irq);
				field_check("housekeeping_irq", want.housekeeping_irq, got.housekeeping_irq);
				field_check("housekeeping_run", want.housekeeping_run, got.housekeeping_run);
				field_check("sound_strobe", want.sound_strobe, got.sound_strobe);
				field_check("solenoid_bits", want.solenoid_bits, got.solenoid_bits);
				field_check("solenoid_bits_high", want.solenoid_bits_high,
					got.solenoid_bits_high);
				field_check("diag_segments", want.diag_segments, got.diag_segments);
				field_check("seg_valid", want.seg_valid, got.seg_valid);
				field_check("seg_index", want.seg_index, got.seg_index);
				field_check("seg_word", want.seg_word, got.seg_word);
				field_check("last", want.last, got.last);
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	initial begin : watchdog
		io_state = '0;
		items_taken = 0;
		idle_cycles = 0;
		mismatches = 0;
		@(posedge arst_n);
		while (idle_cycles < IdleLimit) @(negedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin : finish_run
		wait (stim_done);
		while (results_due.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
design/pinio_pkg.sv
design/pinio_if.sv
design/pinio_decode.sv
design/pinball_io_register_block.sv
bench/tb_pinball_io_register_block.sv
